FILE: sv/line_rasterizer_pixel_writer_top_assert.svh
// -----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// -----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_PIXEL_WRITER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_PIXEL_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define LRPW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LRPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lrpw_pkg.sv
// -----------------------------------------------------------------------------
// Line rasterizer package
// Shared constants, codes and the configuration register bundle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrpw_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_DIM_BITS   = 12;
	localparam int CFG_BPP_BITS   = 3;
	localparam int OFFSET_BITS    = 24;
	localparam int COLOR_BITS     = 32;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_BITS   = 2;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BYTES_PER_PX = 2'd2;

	// reset values
	localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_WIDTH  = 12'd320;
	localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_HEIGHT = 12'd240;
	localparam logic [CFG_BPP_BITS-1:0] RST_BYTES_PER_PX = 3'd2;

	typedef struct packed {
		logic [CFG_DIM_BITS-1:0] frame_width;
		logic [CFG_DIM_BITS-1:0] frame_height;
		logic [CFG_BPP_BITS-1:0] bytes_per_pixel;
	} cfg_regs_t;

endpackage

`default_nettype wire

FILE: sv/lrpw_front.sv
// -----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts input words, splits off the operation and queues the commands.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrpw_front
	import lrpw_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
	input  wire logic                                    s_tuser,
	output logic                                         cmd_valid,
	input  wire logic                                    cmd_ready,
	output logic                                         cmd_op,
	output logic [4*COORD_BITS+COLOR_BITS-1:0]           cmd_data
);

	localparam int PAY_BITS = 4*COORD_BITS + COLOR_BITS;
	localparam int IW       = $clog2(QUEUE_DEPTH);
	localparam logic [IW:0] FULL_CNT = (IW+1)'(QUEUE_DEPTH);

	logic [PAY_BITS:0] mem_q [QUEUE_DEPTH];
	logic [IW-1:0]     head_q, tail_q;
	logic [IW:0]       count_q;
	logic              push, pop;

	assign s_tready  = (count_q != FULL_CNT);
	assign cmd_valid = (count_q != '0);
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	assign cmd_op   = mem_q[head_q][PAY_BITS];
	assign cmd_data = mem_q[head_q][PAY_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + IW'(1);
			end
			if (pop) begin
				head_q <= head_q + IW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (IW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (IW+1)'(1);
			end
		end
	end

	// queue storage, operation bit and payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= {s_tuser, s_tdata[PAY_BITS-1:0]};
		end
	end

endmodule

`default_nettype wire

FILE: sv/lrpw_back.sv
// -----------------------------------------------------------------------------
// Line rasterizer back end
// Bresenham stepper followed by a stalling byte-offset pipeline.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "line_rasterizer_pixel_writer_top_assert.svh"

module lrpw_back
	import lrpw_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire cfg_regs_t                                 cfg,
	input  wire logic                                      cmd_valid,
	output logic                                           cmd_ready,
	input  wire logic                                      cmd_op,
	input  wire logic [4*COORD_BITS+COLOR_BITS-1:0]        cmd_data,
	output logic                                           m_tvalid,
	input  wire logic                                      m_tready,
	output logic [((2*COORD_BITS+OFFSET_BITS+COLOR_BITS+8)/8)*8-1:0] m_tdata,
	output logic                                           m_tlast
);

	localparam int CB       = COORD_BITS;
	localparam int OUT_BITS = 2*CB + 1 + OFFSET_BITS + COLOR_BITS;
	localparam int OUT_W    = ((OUT_BITS+7)/8)*8;
	localparam int CW       = (CB > CFG_DIM_BITS) ? CB : CFG_DIM_BITS;
	localparam int PW       = CB + CFG_DIM_BITS;
	localparam int EW       = (PW > OFFSET_BITS) ? PW : OFFSET_BITS;
	localparam int SW       = OFFSET_BITS + CFG_BPP_BITS;

	// line state
	logic [CB-1:0]          cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic signed [CB:0]     dx_q, dyn_q;
	logic signed [CB+1:0]   err_q;
	logic                   sxn_q, syn_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic                   active_q;

	// pipeline
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [CB-1:0]          px_s1, px_s2, px_s3, px_s4;
	logic [CB-1:0]          py_s1, py_s2, py_s3, py_s4;
	logic                   in_s1, in_s2, in_s3, in_s4;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic [COLOR_BITS-1:0]  col_s1, col_s2, col_s3, col_s4;
	logic [OFFSET_BITS-1:0] prod_s2, sum_s3, off_s4;

	logic advance, take;

	// command decode
	logic [CB-1:0]        x1, y1, x2, y2;
	logic signed [CB:0]   ddx, ddy, adx, ady;

	// step logic
	logic                 pix_in, pix_last;
	logic signed [CB+2:0] e2;
	logic                 mv_x, mv_y;
	logic signed [CB+1:0] add_x, add_y;

	// offset arithmetic
	logic [PW-1:0] prod_full;
	logic [EW-1:0] prod_ext;
	logic [SW-1:0] scaled;

	assign advance   = !(v_s4 && !m_tready);
	assign take      = cmd_valid && advance;
	assign cmd_ready = advance;

	assign x1 = cmd_data[0*CB +: CB];
	assign y1 = cmd_data[1*CB +: CB];
	assign x2 = cmd_data[2*CB +: CB];
	assign y2 = cmd_data[3*CB +: CB];

	assign ddx = $signed({x2[CB-1], x2}) - $signed({x1[CB-1], x1});
	assign ddy = $signed({y2[CB-1], y2}) - $signed({y1[CB-1], y1});
	assign adx = ddx[CB] ? -ddx : ddx;
	assign ady = ddy[CB] ? -ddy : ddy;

	assign pix_in = !cur_x_q[CB-1] && !cur_y_q[CB-1]
		&& (CW'(cur_x_q) < CW'(cfg.frame_width))
		&& (CW'(cur_y_q) < CW'(cfg.frame_height));
	assign pix_last = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

	assign e2    = {err_q, 1'b0};
	assign mv_x  = e2 >= (CB+3)'(dyn_q);
	assign mv_y  = e2 <= (CB+3)'(dx_q);
	assign add_x = mv_x ? (CB+2)'(dyn_q) : '0;
	assign add_y = mv_y ? (CB+2)'(dx_q) : '0;

	assign prod_full = PW'(py_s1) * PW'(cfg.frame_width);
	assign prod_ext  = EW'(prod_full);
	assign scaled    = SW'(sum_s3) * SW'(cfg.bytes_per_pixel);

	// line state: start loads, an active step advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (take) begin
			if (cmd_op == OP_START) begin
				active_q <= 1'b1;
			end else if (active_q && pix_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (cmd_op == OP_START) begin
				cur_x_q <= x1;
				cur_y_q <= y1;
				tgt_x_q <= x2;
				tgt_y_q <= y2;
				dx_q    <= adx;
				dyn_q   <= -ady;
				sxn_q   <= (ddx <= 0);
				syn_q   <= (ddy <= 0);
				err_q   <= (CB+2)'(adx) - (CB+2)'(ady);
				color_q <= cmd_data[4*CB +: COLOR_BITS];
			end else if (active_q && !pix_last) begin
				err_q <= err_q + add_x + add_y;
				if (mv_x) begin
					cur_x_q <= sxn_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
				end
				if (mv_y) begin
					cur_y_q <= syn_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
				end
			end
		end
	end

	// valid chain, frozen as a whole on output stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= take && (cmd_op == OP_STEP) && active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			px_s1   <= cur_x_q;
			py_s1   <= cur_y_q;
			in_s1   <= pix_in;
			last_s1 <= pix_last;
			col_s1  <= color_q;

			px_s2   <= px_s1;
			py_s2   <= py_s1;
			in_s2   <= in_s1;
			last_s2 <= last_s1;
			col_s2  <= col_s1;
			prod_s2 <= prod_ext[OFFSET_BITS-1:0];

			px_s3   <= px_s2;
			py_s3   <= py_s2;
			in_s3   <= in_s2;
			last_s3 <= last_s2;
			col_s3  <= col_s2;
			sum_s3  <= prod_s2 + OFFSET_BITS'(px_s2);

			px_s4   <= px_s3;
			py_s4   <= py_s3;
			in_s4   <= in_s3;
			last_s4 <= last_s3;
			col_s4  <= col_s3;
			off_s4  <= in_s3 ? scaled[OFFSET_BITS-1:0] : '0;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tlast  = last_s4;
	assign m_tdata  = OUT_W'({col_s4, off_s4, in_s4, py_s4, px_s4});

	`LRPW_ASSERT_NEXT(a_start_arms, take && cmd_op == OP_START, active_q && !v_s1,
		"start did not arm the line")
	`LRPW_ASSERT_NEXT(a_idle_step_silent, take && cmd_op == OP_STEP && !active_q, !v_s1,
		"step without a line produced a pixel")
	`LRPW_ASSERT_NEXT(a_last_ends_line, take && cmd_op == OP_STEP && active_q && pix_last,
		!active_q && v_s1 && last_s1, "end pixel did not close the line")
	`LRPW_ASSERT_NEXT(a_stall_freezes, m_tvalid && !m_tready,
		$stable(v_s1) && $stable(v_s2) && $stable(v_s3) && $stable(active_q),
		"pipeline moved during output stall")

endmodule

`default_nettype wire

FILE: sv/line_rasterizer_pixel_writer_top.sv
// -----------------------------------------------------------------------------
// Line rasterizer pixel writer, top level
// Bresenham line engine emitting clipped pixels with framebuffer byte offsets.
// -----------------------------------------------------------------------------
//
// Channel  Dir  Word contents (lowest bit first)
// -------  ---  ---------------------------------------------------------------
// s_*      in   tdata: start_x, start_y, end_x, end_y, line_color; tuser: op
// m_*      out  tdata: pixel_x, pixel_y, in_bounds, byte_offset, pixel_color;
//               tlast: end point of the line
// cfg_*    in   cfg_index: register (width, height, bytes/pixel); cfg_data
//
// Sustained rate is one word per cycle while m_tready is high: the back end
// takes one queued command a cycle; the offset path (multiply, add, scale) is
// four register stages deep. A step word passes the queue, then s1 to s4.
// A four-entry command queue sits between input and engine; a pixel waiting
// on m_tready low freezes the whole back end while the queue keeps filling.
// Reset empties the queue and pipeline, drops any active line and loads the
// registers with 320 x 240, two bytes per pixel. Configuration is always ready.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_pixel_writer_top
	import lrpw_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// input stream
	input  wire logic s_tvalid,
	output logic      s_tready,
	// start_x, start_y, end_x, end_y, line_color, zero fill
	input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
	// operation
	input  wire logic s_tuser,
	// pixel stream
	output logic      m_tvalid,
	input  wire logic m_tready,
	// pixel_x, pixel_y, in_bounds, byte_offset, pixel_color, zero fill
	output logic [((2*COORD_BITS+OFFSET_BITS+COLOR_BITS+8)/8)*8-1:0] m_tdata,
	// last
	output logic      m_tlast,
	// configuration writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DIM_BITS-1:0] cfg_data
);

	localparam int PAY_BITS = 4*COORD_BITS + COLOR_BITS;

	cfg_regs_t             cfg_q;
	logic                  cmd_valid, cmd_ready, cmd_op;
	logic [PAY_BITS-1:0]   cmd_data;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= RST_FRAME_WIDTH;
			cfg_q.frame_height    <= RST_FRAME_HEIGHT;
			cfg_q.bytes_per_pixel <= RST_BYTES_PER_PX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data;
				end
				CFG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data;
				end
				CFG_BYTES_PER_PX: begin
					cfg_q.bytes_per_pixel <= cfg_data[CFG_BPP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: accept and queue commands
	lrpw_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_op   (cmd_op),
		.cmd_data (cmd_data)
	);

	// back: line stepping and pixel addressing
	lrpw_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_op   (cmd_op),
		.cmd_data (cmd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
